// ===== src/inflator_waveshaper_mix_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the inflator waveshaper
// Shared property shorthands, sampled on the rising clock edge and disabled
// while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INFLATOR_WAVESHAPER_MIX_TOP_DEFINES_SVH
`define INFLATOR_WAVESHAPER_MIX_TOP_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define IWS_ASSERT_NOW(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define IWS_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/iws_pkg.sv =====
// ----------------------------------------------------------------------------
// iws_pkg - shared definitions for the inflator waveshaper
// Widths, fixed-point constants, register indexes and the transaction types
// passed between the front end, the queues and the shaping back end.
// ----------------------------------------------------------------------------
`default_nettype none

package iws_pkg;

  // Sample format: signed, FRAC fraction bits.
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC        = SAMPLE_BITS - 1;

  // Configuration field widths.
  localparam int GAIN_W     = 14;
  localparam int CURVE_W    = 11;
  localparam int MIXAMT_W   = 11;
  localparam int OGAIN_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_SHAPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MIX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPER_ENABLE = 3'd4;

  // Register reset values and limits.
  localparam logic [GAIN_W-1:0]   INPUT_GAIN_RST  = 14'd4096;
  localparam logic [CURVE_W-1:0]  CURVE_RST       = 11'd512;
  localparam logic [CURVE_W-1:0]  CURVE_MAX       = 11'd1024;
  localparam logic [MIXAMT_W-1:0] MIX_RST         = 11'd0;
  localparam logic [MIXAMT_W-1:0] MIX_FULL        = 11'd1024;
  localparam logic [OGAIN_W-1:0]  OGAIN_RST       = 13'd4096;
  localparam logic [OGAIN_W-1:0]  OGAIN_MAX       = 13'd4096;

  // Input gain arithmetic (Q2.12 gain).
  localparam int GAIN_FRAC = 12;
  localparam int GAIN_PW   = SAMPLE_BITS + GAIN_W + 1;

  // Clamped sample (+-2.0) and its magnitude.
  localparam int XW   = SAMPLE_BITS + 2;
  localparam int MAGW = SAMPLE_BITS + 1;

  // Curve coefficients: A, B, C in units of 2^-10 scaled by 4096, D in Q.22.
  localparam int KW        = 12;
  localparam int KDW       = 21;
  localparam int KEW       = 11;
  localparam int KA_BASE   = 1536;
  localparam int CURVE_MID = 512;
  localparam int KSCALE_SH = 12;
  localparam int COEF_SH   = 22;

  // Back end datapath widths.
  localparam int SQW   = 2 * SAMPLE_BITS;
  localparam int UPW   = 2 * SAMPLE_BITS + 1;
  localparam int PAW   = SAMPLE_BITS + KW;
  localparam int PBW   = SAMPLE_BITS + KW + 1;
  localparam int TW    = SAMPLE_BITS + 3;
  localparam int ACCW  = SAMPLE_BITS + 26;
  localparam int WETW  = ACCW - COEF_SH;
  localparam int MIXW  = WETW + MIXAMT_W + 2;
  localparam int PRODW = MIXW + OGAIN_W + 1;
  localparam int OUT_SH = 22;
  localparam int YW    = PRODW - OUT_SH;

  // Queues and pipeline.
  localparam int MQ_DEPTH    = 4;
  localparam int MQ_AW       = $clog2(MQ_DEPTH);
  localparam int MQ_CW       = $clog2(MQ_DEPTH + 1);
  localparam int OQ_DEPTH    = 16;
  localparam int OQ_AW       = $clog2(OQ_DEPTH);
  localparam int OQ_CW       = $clog2(OQ_DEPTH + 1);
  localparam int BACK_STAGES = 6;

  // Which segment of the curve a sample falls in.
  typedef enum logic [1:0] {
    BAND_QUART,
    BAND_UPPER,
    BAND_ZERO
  } band_t;

  typedef struct packed {
    logic [GAIN_W-1:0]   input_gain;
    logic [CURVE_W-1:0]  curve_shape;
    logic [MIXAMT_W-1:0] effect_mix;
    logic [OGAIN_W-1:0]  output_gain;
    logic                shaper_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic [MAGW-1:0]      mag;
    logic                 neg;
    band_t                band;
  } mid_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sat;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/inflator_waveshaper_mix_top.sv =====
// ----------------------------------------------------------------------------
// inflator_waveshaper_mix_top - polynomial inflator waveshaper with dry/wet mix
// Input gain and clamp, inflator curve, mix, output gain and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Input side looks like a queue: drive in_sample_in and raise in_push; the
//   sample is taken on a clock edge where in_full is low.
//   Result side looks like a queue: while out_empty is low, out_sample_out
//   and out_saturated show the oldest result; pop it with out_pop.
//   Configuration: cfg_index selects the register (input gain, curve shape,
//   effect mix, output gain, shaper enable), cfg_wdata carries the value.
//   cfg_ready is always high; unknown indexes are dropped. Write only while
//   no samples are in flight.
// Timing:
//   A result passes the input register, the mid queue, the six-stage back-end
//   pipeline and the result queue. One sample per cycle is sustained, and the
//   pipeline issues one each cycle, while the result queue has room.
//   When the receiver stalls, the 16-entry result queue absorbs samples in
//   flight, then the 4-entry mid queue fills and in_full rises.
// Reset:
//   rst_n (synchronous, active low) empties both queues and the pipeline and
//   restores all registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inflator_waveshaper_mix_top_defines.svh"

module inflator_waveshaper_mix_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input channel
  input  logic                                   in_push,
  input  logic signed [iws_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  output logic                                   in_full,
  // result channel
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [iws_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  output logic                                   out_saturated,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [iws_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [iws_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  iws_pkg::cfg_t      cfg_r, cfg_nxt;
  logic               cfg_we;
  logic               mq_push, mq_pop, mq_empty;
  iws_pkg::mid_item_t mq_wr_item, mq_rd_item;
  logic               oq_push;
  iws_pkg::out_item_t oq_wr_item, oq_rd_item;
  logic               out_taken;

  // Configuration registers: a transaction completes every cycle valid is high.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        iws_pkg::REG_INPUT_GAIN:    cfg_nxt.input_gain    = cfg_wdata[iws_pkg::GAIN_W-1:0];
        iws_pkg::REG_CURVE_SHAPE:   cfg_nxt.curve_shape   = cfg_wdata[iws_pkg::CURVE_W-1:0];
        iws_pkg::REG_EFFECT_MIX:    cfg_nxt.effect_mix    = cfg_wdata[iws_pkg::MIXAMT_W-1:0];
        iws_pkg::REG_OUTPUT_GAIN:   cfg_nxt.output_gain   = cfg_wdata[iws_pkg::OGAIN_W-1:0];
        iws_pkg::REG_SHAPER_ENABLE: cfg_nxt.shaper_enable = cfg_wdata[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_gain    <= iws_pkg::INPUT_GAIN_RST;
      cfg_r.curve_shape   <= iws_pkg::CURVE_RST;
      cfg_r.effect_mix    <= iws_pkg::MIX_RST;
      cfg_r.output_gain   <= iws_pkg::OGAIN_RST;
      cfg_r.shaper_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: gain, clamp and classify.
  iws_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_sample  (in_sample_in),
    .in_full    (in_full),
    .input_gain (cfg_r.input_gain),
    .mq_pop     (mq_pop),
    .mq_push    (mq_push),
    .mq_item    (mq_wr_item)
  );

  // Decouple front and back so each can stall on its own.
  iws_midq u_midq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (mq_push),
    .item_in  (mq_wr_item),
    .pop      (mq_pop),
    .item_out (mq_rd_item),
    .empty    (mq_empty)
  );

  // Back end: curve, mix and output gain.
  iws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mq_empty  (mq_empty),
    .mq_item   (mq_rd_item),
    .mq_pop    (mq_pop),
    .out_taken (out_taken),
    .oq_push   (oq_push),
    .oq_item   (oq_wr_item)
  );

  // Hold finished results until the receiver pops them.
  assign out_taken = out_pop && !out_empty;

  iws_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (oq_push),
    .item_in  (oq_wr_item),
    .pop      (out_taken),
    .item_out (oq_rd_item),
    .empty    (out_empty)
  );

  assign out_sample_out = oq_rd_item.sample;
  assign out_saturated  = oq_rd_item.sat;

  `IWS_ASSERT_NOW(a_sat_at_rail, clk, rst_n, !out_empty && out_saturated, (out_sample_out == $signed({1'b0, {iws_pkg::FRAC{1'b1}}})) || (out_sample_out == $signed({1'b1, {iws_pkg::FRAC{1'b0}}})), "saturated result not at full scale")

endmodule

`default_nettype wire

// ===== src/iws_front.sv =====
// ----------------------------------------------------------------------------
// iws_front - input stage of the inflator waveshaper
// Takes samples, applies the input gain with rounding, clamps to +-2.0 and
// sorts each sample into its curve segment before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module iws_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  input  logic signed [iws_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                  in_full,
  input  logic [iws_pkg::GAIN_W-1:0]            input_gain,
  input  logic                                  mq_pop,
  output logic                                  mq_push,
  output iws_pkg::mid_item_t                    mq_item
);

  logic                                  v0_r, v0_nxt;
  logic signed [iws_pkg::SAMPLE_BITS-1:0] s0_r;
  logic [iws_pkg::MQ_CW-1:0]             mocc_r, mocc_nxt;
  logic                                  accept;
  logic signed [iws_pkg::GAIN_PW-1:0]    prod;
  logic signed [iws_pkg::GAIN_PW-1:0]    scaled;
  logic signed [iws_pkg::GAIN_PW-1:0]    two_w;
  logic signed [iws_pkg::XW-1:0]         x_c;
  logic [iws_pkg::MAGW-1:0]              mag_c;

  // Credit count covers the input register plus the queue entries.
  assign in_full = (mocc_r >= iws_pkg::MQ_CW'(iws_pkg::MQ_DEPTH));
  assign accept  = in_push && !in_full;
  assign mq_push = v0_r;

  always_comb begin
    v0_nxt   = accept;
    mocc_nxt = mocc_r + iws_pkg::MQ_CW'(accept) - iws_pkg::MQ_CW'(mq_pop);

    two_w  = iws_pkg::GAIN_PW'(1) <<< iws_pkg::SAMPLE_BITS;
    prod   = iws_pkg::GAIN_PW'(s0_r) * iws_pkg::GAIN_PW'($signed({1'b0, input_gain}));
    scaled = (prod + (iws_pkg::GAIN_PW'(1) <<< (iws_pkg::GAIN_FRAC - 1)))
             >>> iws_pkg::GAIN_FRAC;

    // Clamp to +-2.0.
    if (scaled > two_w) begin
      x_c = iws_pkg::XW'(two_w);
    end else if (scaled < -two_w) begin
      x_c = iws_pkg::XW'(-two_w);
    end else begin
      x_c = iws_pkg::XW'(scaled);
    end

    mag_c = iws_pkg::MAGW'(x_c[iws_pkg::XW-1] ? -x_c : x_c);

    mq_item.x   = x_c;
    mq_item.mag = mag_c;
    mq_item.neg = x_c[iws_pkg::XW-1];
    if (mag_c >= (iws_pkg::MAGW'(1) << iws_pkg::SAMPLE_BITS)) begin
      mq_item.band = iws_pkg::BAND_ZERO;
    end else if (mag_c > (iws_pkg::MAGW'(1) << iws_pkg::FRAC)) begin
      mq_item.band = iws_pkg::BAND_UPPER;
    end else begin
      mq_item.band = iws_pkg::BAND_QUART;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      mocc_r <= '0;
    end else begin
      v0_r   <= v0_nxt;
      mocc_r <= mocc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_r <= in_sample;
    end
  end

endmodule

`default_nettype wire

// ===== src/iws_midq.sv =====
// ----------------------------------------------------------------------------
// iws_midq - queue between front end and back end
// Short register queue holding classified samples so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inflator_waveshaper_mix_top_defines.svh"

module iws_midq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iws_pkg::mid_item_t item_in,
  input  logic               pop,
  output iws_pkg::mid_item_t item_out,
  output logic               empty
);

  iws_pkg::mid_item_t          mem_r [iws_pkg::MQ_DEPTH];
  logic [iws_pkg::MQ_AW-1:0]   wp_r, wp_nxt;
  logic [iws_pkg::MQ_AW-1:0]   rp_r, rp_nxt;
  logic [iws_pkg::MQ_CW-1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + iws_pkg::MQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + iws_pkg::MQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + iws_pkg::MQ_CW'(push) - iws_pkg::MQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_in;
    end
  end

  `IWS_ASSERT_NOW(a_mq_no_overflow, clk, rst_n, push, cnt_r < iws_pkg::MQ_CW'(iws_pkg::MQ_DEPTH), "mid queue overflow")
  `IWS_ASSERT_NOW(a_mq_no_underflow, clk, rst_n, pop, cnt_r != '0, "mid queue underflow")

endmodule

`default_nettype wire

// ===== src/iws_back.sv =====
// ----------------------------------------------------------------------------
// iws_back - shaping back end of the inflator waveshaper
// Six-stage pipeline: powers, coefficient products, quartic sum, sign and
// segment select, dry/wet mix, output gain with rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module iws_back (
  input  logic               clk,
  input  logic               rst_n,
  input  iws_pkg::cfg_t      cfg,
  input  logic               mq_empty,
  input  iws_pkg::mid_item_t mq_item,
  output logic               mq_pop,
  input  logic               out_taken,
  output logic               oq_push,
  output iws_pkg::out_item_t oq_item
);

  localparam int SB = iws_pkg::SAMPLE_BITS;
  localparam int NS = iws_pkg::BACK_STAGES;

  typedef struct packed {
    logic signed [iws_pkg::XW-1:0] x;
    logic                          neg;
    iws_pkg::band_t                band;
    logic [SB-1:0]                 up;
  } pass_t;

  // Coefficients and clamped settings, refreshed every cycle.
  logic [iws_pkg::KW-1:0]          ka_r, ka_nxt;
  logic signed [iws_pkg::KW-1:0]   kb_r, kb_nxt;
  logic signed [iws_pkg::KW-1:0]   kc_r, kc_nxt;
  logic [iws_pkg::KDW-1:0]         kd_r, kd_nxt;
  logic [iws_pkg::MIXAMT_W-1:0]    mix_r, mix_nxt;
  logic [iws_pkg::OGAIN_W-1:0]     og_r, og_nxt;
  logic                            en_r, en_nxt;
  logic [iws_pkg::CURVE_W-1:0]     curve_c;
  logic signed [iws_pkg::KW-1:0]   cp;
  logic [iws_pkg::KEW-1:0]         ke;

  logic [iws_pkg::OQ_CW-1:0]       occ_r, occ_nxt;
  logic [NS-1:0]                   vld_r, vld_nxt;
  logic                            issue;

  // Stage 1
  logic [SB-1:0]                   s1q;
  logic [iws_pkg::SQW-1:0]         sq;
  logic [SB-1:0]                   span;
  logic [iws_pkg::UPW-1:0]         upp;
  pass_t                           p1_nxt, p1_r;
  logic [SB-1:0]                   s1_1_r, s2_1_r, s2_c;
  // Stage 2
  logic [iws_pkg::SQW-1:0]         p3, p4;
  logic [SB-1:0]                   s3_c, s4_c;
  logic [iws_pkg::PAW-1:0]         pa_c;
  logic signed [iws_pkg::PBW-1:0]  pb_c;
  pass_t                           p2_r;
  logic [SB-1:0]                   s2_2_r, s3_2_r, s4_2_r;
  logic [iws_pkg::PAW-1:0]         pa2_r;
  logic signed [iws_pkg::PBW-1:0]  pb2_r;
  // Stage 3
  logic signed [iws_pkg::ACCW-1:0] pab_c, pc_c, pd_c;
  logic signed [iws_pkg::TW-1:0]   t_c;
  pass_t                           p3_r;
  logic signed [iws_pkg::ACCW-1:0] pab3_r, pc3_r, pd3_r;
  // Stage 4
  logic signed [iws_pkg::ACCW-1:0] acc_c, accr_c;
  logic signed [iws_pkg::WETW-1:0] qmag, smag, wet_c;
  logic signed [iws_pkg::WETW-1:0] wet4_r;
  logic signed [iws_pkg::XW-1:0]   dry4_r;
  // Stage 5
  logic [iws_pkg::MIXAMT_W-1:0]    dmix;
  logic signed [iws_pkg::MIXW-1:0] ms_c, ms5_r;
  // Stage 6
  logic signed [iws_pkg::PRODW-1:0] pr_c, pr6_r, yr_c;
  logic signed [iws_pkg::YW-1:0]    y_c, y_max, y_min;

  // Issue only with room reserved in the output queue.
  assign issue  = !mq_empty && (occ_r < iws_pkg::OQ_CW'(iws_pkg::OQ_DEPTH));
  assign mq_pop = issue;
  assign oq_push = vld_r[NS-1];

  always_comb begin
    occ_nxt = occ_r + iws_pkg::OQ_CW'(issue) - iws_pkg::OQ_CW'(out_taken);
    vld_nxt = {vld_r[NS-2:0], issue};

    curve_c = (cfg.curve_shape > iws_pkg::CURVE_MAX) ? iws_pkg::CURVE_MAX : cfg.curve_shape;
    cp      = $signed({1'b0, curve_c}) - iws_pkg::KW'(iws_pkg::CURVE_MID);
    ka_nxt  = iws_pkg::KW'(cp + iws_pkg::KW'(iws_pkg::KA_BASE));
    kb_nxt  = -(cp <<< 1);
    kc_nxt  = cp - iws_pkg::KW'(iws_pkg::CURVE_MID);
    ke      = iws_pkg::KEW'(iws_pkg::KW'(iws_pkg::CURVE_MID) - cp);
    kd_nxt  = iws_pkg::KDW'(ke) * iws_pkg::KDW'(ke);
    mix_nxt = (cfg.effect_mix > iws_pkg::MIX_FULL) ? iws_pkg::MIX_FULL : cfg.effect_mix;
    og_nxt  = (cfg.output_gain > iws_pkg::OGAIN_MAX) ? iws_pkg::OGAIN_MAX : cfg.output_gain;
    en_nxt  = cfg.shaper_enable;
  end

  // Stage 1: square for the quartic, and the upper band product.
  always_comb begin
    s1q  = mq_item.mag[SB-1:0];
    sq   = iws_pkg::SQW'(s1q) * iws_pkg::SQW'(s1q);
    s2_c = SB'((sq + (iws_pkg::SQW'(1) << (iws_pkg::FRAC - 1))) >> iws_pkg::FRAC);
    span = SB'((iws_pkg::MAGW'(1) << SB) - mq_item.mag);
    upp  = iws_pkg::UPW'(mq_item.mag) * iws_pkg::UPW'(span);
    p1_nxt.x    = mq_item.x;
    p1_nxt.neg  = mq_item.neg;
    p1_nxt.band = mq_item.band;
    p1_nxt.up   = SB'((upp + (iws_pkg::UPW'(1) << (iws_pkg::FRAC - 1))) >> iws_pkg::FRAC);
  end

  // Stage 2: cube, fourth power, and the A and B products.
  always_comb begin
    p3   = iws_pkg::SQW'(s2_1_r) * iws_pkg::SQW'(s1_1_r);
    p4   = iws_pkg::SQW'(s2_1_r) * iws_pkg::SQW'(s2_1_r);
    s3_c = SB'((p3 + (iws_pkg::SQW'(1) << (iws_pkg::FRAC - 1))) >> iws_pkg::FRAC);
    s4_c = SB'((p4 + (iws_pkg::SQW'(1) << (iws_pkg::FRAC - 1))) >> iws_pkg::FRAC);
    pa_c = iws_pkg::PAW'(ka_r) * iws_pkg::PAW'(s1_1_r);
    pb_c = iws_pkg::PBW'(kb_r) * iws_pkg::PBW'($signed({1'b0, s2_1_r}));
  end

  // Stage 3: C product and the D term on x^2 - 2x^3 + x^4.
  always_comb begin
    pab_c = iws_pkg::ACCW'($signed({1'b0, pa2_r})) + iws_pkg::ACCW'(pb2_r);
    pc_c  = iws_pkg::ACCW'(kc_r) * iws_pkg::ACCW'($signed({1'b0, s3_2_r}));
    t_c   = iws_pkg::TW'($signed({1'b0, s2_2_r}))
            - (iws_pkg::TW'($signed({1'b0, s3_2_r})) <<< 1)
            + iws_pkg::TW'($signed({1'b0, s4_2_r}));
    pd_c  = iws_pkg::ACCW'($signed({1'b0, kd_r})) * iws_pkg::ACCW'(t_c);
  end

  // Stage 4: round the quartic, pick segment and sign, or pass x when disabled.
  always_comb begin
    acc_c  = ((pab3_r + pc3_r) <<< iws_pkg::KSCALE_SH) - pd3_r;
    accr_c = acc_c + (iws_pkg::ACCW'(1) <<< (iws_pkg::COEF_SH - 1));
    qmag   = iws_pkg::WETW'(accr_c >>> iws_pkg::COEF_SH);
    case (p3_r.band)
      iws_pkg::BAND_QUART: smag = qmag;
      iws_pkg::BAND_UPPER: smag = iws_pkg::WETW'($signed({1'b0, p3_r.up}));
      iws_pkg::BAND_ZERO:  smag = '0;
      default:             smag = '0;
    endcase
    if (en_r) begin
      wet_c = p3_r.neg ? -smag : smag;
    end else begin
      wet_c = iws_pkg::WETW'(p3_r.x);
    end
  end

  // Stage 5 and 6: mix, output gain, then round and saturate.
  always_comb begin
    dmix = iws_pkg::MIX_FULL - mix_r;
    ms_c = iws_pkg::MIXW'(dry4_r) * iws_pkg::MIXW'($signed({1'b0, dmix}))
         + iws_pkg::MIXW'(wet4_r) * iws_pkg::MIXW'($signed({1'b0, mix_r}));
    pr_c = iws_pkg::PRODW'(ms5_r) * iws_pkg::PRODW'($signed({1'b0, og_r}));

    yr_c  = pr6_r + (iws_pkg::PRODW'(1) <<< (iws_pkg::OUT_SH - 1));
    y_c   = iws_pkg::YW'(yr_c >>> iws_pkg::OUT_SH);
    y_max = iws_pkg::YW'($signed({1'b0, {iws_pkg::FRAC{1'b1}}}));
    y_min = iws_pkg::YW'($signed({1'b1, {iws_pkg::FRAC{1'b0}}}));
    if (y_c > y_max) begin
      oq_item.sample = SB'(y_max);
      oq_item.sat    = 1'b1;
    end else if (y_c < y_min) begin
      oq_item.sample = SB'(y_min);
      oq_item.sat    = 1'b1;
    end else begin
      oq_item.sample = SB'(y_c);
      oq_item.sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Datapath advances every cycle; vld_r tracks which stages hold a sample.
  always_ff @(posedge clk) begin
    ka_r   <= ka_nxt;
    kb_r   <= kb_nxt;
    kc_r   <= kc_nxt;
    kd_r   <= kd_nxt;
    mix_r  <= mix_nxt;
    og_r   <= og_nxt;
    en_r   <= en_nxt;

    p1_r   <= p1_nxt;
    s1_1_r <= s1q;
    s2_1_r <= s2_c;

    p2_r   <= p1_r;
    s2_2_r <= s2_1_r;
    s3_2_r <= s3_c;
    s4_2_r <= s4_c;
    pa2_r  <= pa_c;
    pb2_r  <= pb_c;

    p3_r   <= p2_r;
    pab3_r <= pab_c;
    pc3_r  <= pc_c;
    pd3_r  <= pd_c;

    wet4_r <= wet_c;
    dry4_r <= p3_r.x;

    ms5_r  <= ms_c;
    pr6_r  <= pr_c;
  end

endmodule

`default_nettype wire

// ===== src/iws_outq.sv =====
// ----------------------------------------------------------------------------
// iws_outq - result queue of the inflator waveshaper
// Holds finished samples until the receiver pops them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "inflator_waveshaper_mix_top_defines.svh"

module iws_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iws_pkg::out_item_t item_in,
  input  logic               pop,
  output iws_pkg::out_item_t item_out,
  output logic               empty
);

  iws_pkg::out_item_t          mem_r [iws_pkg::OQ_DEPTH];
  logic [iws_pkg::OQ_AW-1:0]   wp_r, wp_nxt;
  logic [iws_pkg::OQ_AW-1:0]   rp_r, rp_nxt;
  logic [iws_pkg::OQ_CW-1:0]   cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign item_out = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + iws_pkg::OQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + iws_pkg::OQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + iws_pkg::OQ_CW'(push) - iws_pkg::OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_in;
    end
  end

  `IWS_ASSERT_NOW(a_oq_no_overflow, clk, rst_n, push, cnt_r < iws_pkg::OQ_CW'(iws_pkg::OQ_DEPTH), "result queue overflow")
  `IWS_ASSERT_NEXT(a_oq_drain, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - iws_pkg::OQ_CW'(1), "result queue count did not drop")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inflator waveshaper testbench
// Streams samples through the shaper under many register settings. The
// settings include the range extremes and the out-of-range codes. Random
// gaps are placed on both queue sides, and long receiver holds back-fill the
// block. Every popped result is checked against a bit-exact fixed-point
// prediction of gain, clamp, curve, mix, output gain and saturation.
// ----------------------------------------------------------------------------

module testbench;

  localparam int RESET_CYCLES = 6;
  localparam int PIPE_LATENCY = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RAND_PHASES  = 19;
  localparam int PHASE_ITEMS  = 102;
  localparam int HOLD_CYCLES  = 120;
  localparam int REPORT_LIMIT = 60;

  // No register lives at this index; writes to it must be dropped.
  localparam logic [iws_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

  localparam longint ONE_Q  = longint'(1) << iws_pkg::FRAC;
  localparam longint HALF_Q = longint'(1) << (iws_pkg::FRAC - 1);

  // --------------------------------------------------------------------------
  // Scoreboard: holds a shadow of the registers, predicts each accepted
  // sample and keeps the predicted outputs in arrival order.
  // --------------------------------------------------------------------------
  class shaper_scoreboard;
    iws_pkg::cfg_t      regs;
    iws_pkg::out_item_t awaited_outputs[$];
    int                 errors;
    int                 checked;
    int                 clipped;

    function new();
      regs.input_gain    = iws_pkg::INPUT_GAIN_RST;
      regs.curve_shape   = iws_pkg::CURVE_RST;
      regs.effect_mix    = iws_pkg::MIX_RST;
      regs.output_gain   = iws_pkg::OGAIN_RST;
      regs.shaper_enable = 1'b1;
      errors  = 0;
      checked = 0;
      clipped = 0;
    endfunction

    function void set_reg(logic [iws_pkg::CFG_IDX_W-1:0] idx,
                          logic [iws_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        iws_pkg::REG_INPUT_GAIN:    regs.input_gain    = data[iws_pkg::GAIN_W-1:0];
        iws_pkg::REG_CURVE_SHAPE:   regs.curve_shape   = data[iws_pkg::CURVE_W-1:0];
        iws_pkg::REG_EFFECT_MIX:    regs.effect_mix    = data[iws_pkg::MIXAMT_W-1:0];
        iws_pkg::REG_OUTPUT_GAIN:   regs.output_gain   = data[iws_pkg::OGAIN_W-1:0];
        iws_pkg::REG_SHAPER_ENABLE: regs.shaper_enable = data[0];
        default: ;
      endcase
    endfunction

    // Round half up: add half an LSB, then arithmetic shift (floor).
    function longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint min_of(longint a, longint b);
      return (a < b) ? a : b;
    endfunction

    // Inflator curve on the magnitude, sign restored afterwards.
    function longint bend(longint x);
      longint m, mag, cp, ka, kb, kc, kd, p2, p3, p4, acc;
      m = (x < 0) ? -x : x;
      if (m >= 2 * ONE_Q) begin
        mag = 0;
      end else if (m > ONE_Q) begin
        mag = (m * (2 * ONE_Q - m) + HALF_Q) >> iws_pkg::FRAC;
      end else begin
        cp  = min_of(longint'(regs.curve_shape), longint'(iws_pkg::CURVE_MAX))
              - iws_pkg::CURVE_MID;
        ka  = (iws_pkg::KA_BASE + cp) * 4096;
        kb  = -2 * cp * 4096;
        kc  = (cp - iws_pkg::CURVE_MID) * 4096;
        kd  = 262144 - 1024 * cp + cp * cp;
        p2  = (m * m + HALF_Q) >> iws_pkg::FRAC;
        p3  = (p2 * m + HALF_Q) >> iws_pkg::FRAC;
        p4  = (p2 * p2 + HALF_Q) >> iws_pkg::FRAC;
        acc = ka * m + kb * p2 + kc * p3 - kd * (p2 - 2 * p3 + p4);
        mag = round_shift(acc, iws_pkg::COEF_SH);
      end
      return (x < 0) ? -mag : mag;
    endfunction

    function iws_pkg::out_item_t shape_sample(logic signed [iws_pkg::SAMPLE_BITS-1:0] s);
      iws_pkg::out_item_t res;
      longint             x, dry, wet, mix, og, acc, y;
      x = round_shift(longint'(s) * longint'(regs.input_gain), iws_pkg::GAIN_FRAC);
      if (x > 2 * ONE_Q) x = 2 * ONE_Q;
      if (x < -2 * ONE_Q) x = -2 * ONE_Q;
      dry = x;
      wet = regs.shaper_enable ? bend(x) : x;
      mix = min_of(longint'(regs.effect_mix), longint'(iws_pkg::MIX_FULL));
      og  = min_of(longint'(regs.output_gain), longint'(iws_pkg::OGAIN_MAX));
      acc = (dry * (longint'(iws_pkg::MIX_FULL) - mix) + wet * mix) * og;
      y   = round_shift(acc, iws_pkg::OUT_SH);
      res.sat = 1'b0;
      if (y > ONE_Q - 1) begin
        y = ONE_Q - 1;
        res.sat = 1'b1;
      end
      if (y < -ONE_Q) begin
        y = -ONE_Q;
        res.sat = 1'b1;
      end
      res.sample = y[iws_pkg::SAMPLE_BITS-1:0];
      return res;
    endfunction

    function void note_sample(logic signed [iws_pkg::SAMPLE_BITS-1:0] s);
      awaited_outputs.push_back(shape_sample(s));
    endfunction

    function void check_output(logic signed [iws_pkg::SAMPLE_BITS-1:0] got, logic got_sat);
      iws_pkg::out_item_t want;
      if (awaited_outputs.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result, sample %0d saturated %0b",
                   $time, got, got_sat);
        return;
      end
      want = awaited_outputs.pop_front();
      checked++;
      if (got_sat === 1'b1) clipped++;
      if (got !== want.sample) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: sample_out expected %0d actual %0d",
                   $time, $signed(want.sample), got);
      end
      if (got_sat !== want.sat) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat, got_sat);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_push;
  logic signed [iws_pkg::SAMPLE_BITS-1:0] in_sample_in;
  logic                                   in_full;
  logic                                   out_empty;
  logic                                   out_pop;
  logic signed [iws_pkg::SAMPLE_BITS-1:0] out_sample_out;
  logic                                   out_saturated;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [iws_pkg::CFG_IDX_W-1:0]          cfg_index;
  logic [iws_pkg::CFG_DATA_W-1:0]         cfg_wdata;

  shaper_scoreboard sb;
  int samples_sent;
  int reg_writes;
  int holds_requested;
  int holds_done;
  int cycles;

  inflator_waveshaper_mix_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_sample_in   (in_sample_in),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .out_saturated  (out_saturated),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Corners of the input range plus the points where the curve bands meet
  // under a 2x input gain.
  function automatic logic signed [iws_pkg::SAMPLE_BITS-1:0] edge_sample(int k);
    case (k)
      0:       return iws_pkg::SAMPLE_BITS'(0);
      1:       return iws_pkg::SAMPLE_BITS'(1);
      2:       return iws_pkg::SAMPLE_BITS'(-1);
      3:       return iws_pkg::SAMPLE_BITS'((1 <<< iws_pkg::FRAC) - 1);   // most positive
      4:       return iws_pkg::SAMPLE_BITS'(-(1 <<< iws_pkg::FRAC));      // most negative
      5:       return iws_pkg::SAMPLE_BITS'(1 <<< (iws_pkg::FRAC - 1));   // one half
      6:       return iws_pkg::SAMPLE_BITS'(-(1 <<< (iws_pkg::FRAC - 1)));
      default: return iws_pkg::SAMPLE_BITS'(3 <<< (iws_pkg::FRAC - 2));   // three quarters
    endcase
  endfunction

  function automatic logic signed [iws_pkg::SAMPLE_BITS-1:0] pick_sample();
    int                                     r;
    int                                     v;
    logic signed [iws_pkg::SAMPLE_BITS-1:0] s;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      v = $urandom;
    end else if (r < 70) begin
      v = int'($urandom_range(0, 8191)) - 4096;
    end else if (r < 85) begin
      return edge_sample($urandom_range(0, 7));
    end else begin
      // cluster around one half, where a 2x gain lands on the band edge
      v = (1 <<< (iws_pkg::FRAC - 1)) + int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 1)) v = -v;
    end
    s = v[iws_pkg::SAMPLE_BITS-1:0];
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers: inputs change on the falling edge, handshakes are sampled on
  // the rising edge.
  // --------------------------------------------------------------------------
  task automatic send_sample(input logic signed [iws_pkg::SAMPLE_BITS-1:0] v);
    @(negedge clk);
    in_push      <= 1'b1;
    in_sample_in <= v;
    // hold the transaction until the queue has room
    do @(posedge clk); while (in_full);
    sb.note_sample(v);
    samples_sent++;
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [iws_pkg::CFG_IDX_W-1:0] idx,
                           input logic [iws_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers may only change with nothing in flight: drop push, wait for
  // every predicted output to come back, then let the pipeline go quiet.
  task automatic load_config(input int gain, input int curve, input int mix,
                             input int og, input int en);
    idle_input(1);
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
    write_reg(iws_pkg::REG_INPUT_GAIN,    gain[iws_pkg::CFG_DATA_W-1:0]);
    write_reg(iws_pkg::REG_CURVE_SHAPE,   curve[iws_pkg::CFG_DATA_W-1:0]);
    write_reg(iws_pkg::REG_EFFECT_MIX,    mix[iws_pkg::CFG_DATA_W-1:0]);
    write_reg(iws_pkg::REG_OUTPUT_GAIN,   og[iws_pkg::CFG_DATA_W-1:0]);
    write_reg(iws_pkg::REG_SHAPER_ENABLE, en[iws_pkg::CFG_DATA_W-1:0]);
  endtask

  task automatic send_edges(input int first, input int count);
    for (int k = first; k < first + count; k++) send_sample(edge_sample(k));
  endtask

  // --------------------------------------------------------------------------
  // Receiver: pops with random stalls, runs of steady popping, and long
  // holds on request so the block backs up and raises full.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int steady_left;
    out_pop     = 1'b0;
    steady_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (holds_done < holds_requested) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_done++;
      end
      if (steady_left > 0) begin
        stall = 0;
        steady_left--;
      end else begin
        stall = pick_gap();
        if ($urandom_range(0, 49) == 0) steady_left = $urandom_range(20, 80);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      sb.check_output(out_sample_out, out_saturated);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("inflator_waveshaper_mix_top: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int  gain, curve, mix, og, en;
    bit  steady;
    sb              = new();
    samples_sent    = 0;
    reg_writes      = 0;
    holds_requested = 0;
    holds_done      = 0;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = iws_pkg::REG_INPUT_GAIN;
    cfg_wdata    = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings pass the dry signal straight through.
    send_edges(0, 4);

    // 2x gain, fully wet: hits the quartic, the band edge at one, the upper
    // band and the zero band at minus two. Then a write to a missing
    // register, which must leave everything alone.
    load_config(8192, 512, 1024, 4096, 1);
    write_reg(REG_UNMAPPED, 14'h3FFF);
    send_edges(0, 8);

    // Max gain, fully dry, output gain code above range: saturation.
    load_config(16383, 0, 0, 8191, 1);
    send_edges(3, 2);

    // Curve and mix codes above range act as their maximum.
    load_config(16383, 2047, 2047, 4096, 1);
    send_edges(0, 6);

    // Shaper bypassed at zero output gain, then bypassed at unity.
    load_config(4096, 1024, 1024, 0, 0);
    send_edges(1, 2);
    load_config(8192, 0, 1024, 4096, 0);
    send_edges(3, 2);

    // Random phases, each with its own settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 7))
        0:       gain = 0;
        1:       gain = 16383;
        2:       gain = int'(iws_pkg::INPUT_GAIN_RST);
        default: gain = $urandom_range(0, 16383);
      endcase
      case ($urandom_range(0, 7))
        0:       curve = 0;
        1:       curve = int'(iws_pkg::CURVE_MAX);
        2:       curve = 2047;
        default: curve = $urandom_range(0, 2047);
      endcase
      case ($urandom_range(0, 7))
        0:       mix = 0;
        1:       mix = int'(iws_pkg::MIX_FULL);
        2:       mix = $urandom_range(1025, 2047);
        default: mix = $urandom_range(0, 1024);
      endcase
      case ($urandom_range(0, 7))
        0:       og = 0;
        1:       og = int'(iws_pkg::OGAIN_MAX);
        2:       og = $urandom_range(4097, 8191);
        default: og = $urandom_range(0, 4096);
      endcase
      en = int'($urandom_range(0, 3) != 0);
      load_config(gain, curve, mix, og, en);
      if ($urandom_range(0, 3) == 0)
        write_reg(iws_pkg::CFG_IDX_W'($urandom_range(iws_pkg::REG_SHAPER_ENABLE + 1, 7)),
                  iws_pkg::CFG_DATA_W'($urandom_range(0, 16383)));

      // Phases 2 and 11 push flat out while the receiver holds off; others may too.
      steady = (p == 2) || (p == 11) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 || p == 11) && i == 10) holds_requested++;
        send_sample(pick_sample());
        if (!steady) idle_input(pick_gap());
      end
    end

    // Drain: wait for every prediction to be met, then watch for strays.
    idle_input(1);
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples over %0d register writes and %0d long receiver holds,",
             samples_sent, reg_writes, holds_done);
    $display("  %0d results checked, %0d of them clipped to full scale.",
             sb.checked, sb.clipped);
    if (sb.errors == 0) begin
      $display("inflator_waveshaper_mix_top: match");
    end else begin
      $display("inflator_waveshaper_mix_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/iws_pkg.sv
src/iws_front.sv
src/iws_midq.sv
src/iws_back.sv
src/iws_outq.sv
src/inflator_waveshaper_mix_top.sv
tb/testbench.sv
